### rtl/core/pin_debouncer_with_rebounce_assert.svh
// Assertion macros shared by the debouncer RTL files
`ifndef PIN_DEBOUNCER_WITH_REBOUNCE_ASSERT_SVH
`define PIN_DEBOUNCER_WITH_REBOUNCE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pdb_pkg.sv
// Types, codes and helpers for the pin debouncer
`default_nettype none

package pdb_pkg;

  // Width of the elapsed-time counter
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned OUT_BITS  = 32;
  localparam int unsigned EXT_BITS  = (TIME_BITS > OUT_BITS) ? TIME_BITS : OUT_BITS;

  localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;
  localparam logic [15:0]          INTERVAL_RST = 16'd10;

  // Operation codes of an input beat
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_POLL  = 3'd1,
    OP_WRITE = 3'd2,
    OP_ARM   = 3'd3,
    OP_BEGIN = 3'd4
  } pdb_op_e;

  // One input beat
  typedef struct packed {
    logic [2:0]  op;
    logic        level;
    logic [15:0] rebounce_ms;
  } pdb_item_t;

  // One result beat
  typedef struct packed {
    logic                level;
    logic                changed;
    logic                rising_edge;
    logic                falling_edge;
    logic [OUT_BITS-1:0] elapsed_ms;
  } pdb_result_t;

  // Clamp the counter into the 32-bit output field
  function automatic logic [OUT_BITS-1:0] sat_elapsed(input logic [TIME_BITS-1:0] el);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(el);
    if (ext > EXT_BITS'({OUT_BITS{1'b1}})) begin
      return '1;
    end
    return ext[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/pdb_in_stage.sv
// Input register: holds one beat until the core consumes it
`default_nettype none

module pdb_in_stage (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire pdb_pkg::pdb_item_t  item_i,
  input  wire                      advance_i,
  output logic                     valid_o,
  output pdb_pkg::pdb_item_t       item_o
);
  import pdb_pkg::*;

  logic      valid_q, valid_d;
  pdb_item_t item_q,  item_d;
  logic      load;

  // Take a new beat when empty or when the held beat moves on
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### rtl/core/pdb_core.sv
// Debouncer state and the single-pass update for one beat
`default_nettype none
`include "pin_debouncer_with_rebounce_assert.svh"

module pdb_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [15:0]               cfg_wdata_i,
  input  wire                      valid_i,
  input  wire pdb_pkg::pdb_item_t  item_i,
  output pdb_pkg::pdb_result_t     result_o
);
  import pdb_pkg::*;

  logic                 level_q,    level_d;
  logic                 changed_q,  changed_d;
  logic [TIME_BITS-1:0] elapsed_q,  elapsed_d;
  logic [15:0]          rebounce_q, rebounce_d;
  logic [15:0]          interval_q, interval_d;
  logic                 accept_chg;
  logic                 rb_fire;

  // Poll decisions
  assign accept_chg = (item_i.level != level_q) &&
                      (elapsed_q >= TIME_BITS'(interval_q));
  assign rb_fire    = (rebounce_q != 16'd0) &&
                      (elapsed_q >= TIME_BITS'(rebounce_q));

  // Next state for a config write and for the beat in the input register
  always_comb begin
    level_d    = level_q;
    changed_d  = changed_q;
    elapsed_d  = elapsed_q;
    rebounce_d = rebounce_q;
    interval_d = interval_q;
    if (cfg_we_i) begin
      interval_d = cfg_wdata_i;
      rebounce_d = '0;
    end
    if (valid_i) begin
      unique case (pdb_op_e'(item_i.op))
        OP_TICK: begin
          if (elapsed_q != TIME_MAX) begin
            elapsed_d = elapsed_q + TIME_BITS'(1);
          end
        end
        OP_POLL: begin
          if (accept_chg) begin
            level_d    = item_i.level;
            elapsed_d  = '0;
            rebounce_d = '0;
            changed_d  = 1'b1;
          end else if (rb_fire) begin
            // rebounce: report a change, level stays
            elapsed_d  = '0;
            rebounce_d = '0;
            changed_d  = 1'b1;
          end else begin
            changed_d  = 1'b0;
          end
        end
        OP_WRITE: begin
          level_d = item_i.level;
        end
        OP_ARM: begin
          rebounce_d = item_i.rebounce_ms;
        end
        OP_BEGIN: begin
          level_d    = item_i.level;
          elapsed_d  = '0;
          rebounce_d = '0;
        end
        default: begin
          // unused codes leave the state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 1'b0;
      changed_q  <= 1'b0;
      elapsed_q  <= '0;
      rebounce_q <= '0;
      interval_q <= INTERVAL_RST;
    end else begin
      level_q    <= level_d;
      changed_q  <= changed_d;
      elapsed_q  <= elapsed_d;
      rebounce_q <= rebounce_d;
      interval_q <= interval_d;
    end
  end

  // Result reflects the state after the beat
  always_comb begin
    result_o.level        = level_d;
    result_o.changed      = changed_d;
    result_o.rising_edge  = changed_d && level_d;
    result_o.falling_edge = changed_d && !level_d;
    result_o.elapsed_ms   = sat_elapsed(elapsed_d);
  end

  `PDB_ASSERT_NEXT(a_tick_counts,
    valid_i && (item_i.op == OP_TICK) && !cfg_we_i && (elapsed_q != TIME_MAX),
    elapsed_q == $past(elapsed_q) + TIME_BITS'(1),
    "tick did not advance the elapsed counter")
  `PDB_ASSERT_NEXT(a_accept_restarts,
    valid_i && (item_i.op == OP_POLL) && accept_chg,
    (elapsed_q == '0) && (rebounce_q == '0) && changed_q,
    "accepted change did not restart timer and disarm rebounce")

endmodule

`default_nettype wire

### rtl/core/pin_debouncer_with_rebounce.sv
// Lockout debouncer for one pin: input register, update core, result register.
// Takes one beat per cycle when the result side keeps up. A beat's result passes through
// the input register and then the result register; a stall on the result side can
// hold it in either. The update itself is one compare-and-count step on the elapsed
// counter, so nothing in the core limits the rate. Config writes land at once and
// are meant for an idle block. No clearing pass after reset.
`default_nettype none
`include "pin_debouncer_with_rebounce_assert.svh"

module pin_debouncer_with_rebounce (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  operation_i,
  input  wire         level_in_i,
  input  wire  [15:0] rebounce_ms_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        level_o,
  output logic        changed_o,
  output logic        rising_edge_o,
  output logic        falling_edge_o,
  output logic [31:0] elapsed_ms_o
);
  import pdb_pkg::*;

  pdb_item_t   in_item;
  pdb_item_t   st_item;
  logic        st_valid;
  logic        advance;
  pdb_result_t core_res;
  logic        out_valid_q, out_valid_d;
  pdb_result_t res_q;

  assign in_item.op          = operation_i;
  assign in_item.level       = level_in_i;
  assign in_item.rebounce_ms = rebounce_ms_i;

  // Beat moves from input register to result register when the latter frees up
  assign advance = st_valid && (!out_valid_q || out_ready_i);

  pdb_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (st_valid),
    .item_o     (st_item)
  );

  pdb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (advance),
    .item_i      (st_item),
    .result_o    (core_res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_o        = res_q.level;
  assign changed_o      = res_q.changed;
  assign rising_edge_o  = res_q.rising_edge;
  assign falling_edge_o = res_q.falling_edge;
  assign elapsed_ms_o   = res_q.elapsed_ms;

  `PDB_ASSERT_NOW(a_no_overwrite,
    out_valid_q && !out_ready_i,
    !advance,
    "result register overwritten while stalled")
  `PDB_ASSERT_NEXT(a_held_beat_kept,
    st_valid && !advance,
    st_valid,
    "held input beat dropped")

endmodule

`default_nettype wire

### test/pin_debouncer_with_rebounce_check.sv
// Scoreboard for the pin debouncer: predicts every result beat and compares it
module pin_debouncer_with_rebounce_check (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [2:0]  operation_i,
  input  wire         level_in_i,
  input  wire  [15:0] rebounce_ms_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire         level_i,
  input  wire         changed_i,
  input  wire         rising_edge_i,
  input  wire         falling_edge_i,
  input  wire  [31:0] elapsed_ms_i,
  output int          pending_o,
  output int          mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pdb_pkg::*;

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  // Shadow copy of the debouncer state and its interval register
  logic [15:0]          interval_ms = INTERVAL_RST;
  logic                 pin_level   = 1'b0;
  logic                 change_seen = 1'b0;
  logic [TIME_BITS-1:0] elapsed     = '0;
  logic [15:0]          rebounce_ms = '0;

  pdb_result_t expected_results [$];
  int          mismatches = 0;

  // Apply one input beat to the shadow state and return the result it should produce
  function automatic pdb_result_t debounce_step(input logic [2:0] op, input logic lvl,
                                                input logic [15:0] rb);
    pdb_result_t         res;
    logic [EXT_BITS-1:0] wide;
    case (op)
      OP_TICK: begin
        // counter sticks at all ones
        if (elapsed != TIME_MAX) elapsed = elapsed + TIME_BITS'(1);
      end
      OP_POLL: begin
        if (lvl != pin_level && elapsed >= TIME_BITS'(interval_ms)) begin
          pin_level   = lvl;
          elapsed     = '0;
          rebounce_ms = '0;
          change_seen = 1'b1;
        end else if (rebounce_ms != '0 && elapsed >= TIME_BITS'(rebounce_ms)) begin
          // rebounce fires: flag a change, level stays put
          elapsed     = '0;
          rebounce_ms = '0;
          change_seen = 1'b1;
        end else begin
          change_seen = 1'b0;
        end
      end
      OP_WRITE: begin
        pin_level = lvl;
      end
      OP_ARM: begin
        rebounce_ms = rb;
      end
      OP_BEGIN: begin
        pin_level   = lvl;
        elapsed     = '0;
        rebounce_ms = '0;
      end
      default: begin
        // unknown codes leave the state alone
      end
    endcase
    wide             = EXT_BITS'(elapsed);
    res.level        = pin_level;
    res.changed      = change_seen;
    res.rising_edge  = change_seen & pin_level;
    res.falling_edge = change_seen & ~pin_level;
    res.elapsed_ms   = (wide > EXT_BITS'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(wide);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare result beats, track config writes, predict accepted input beats
  always @(posedge clk_i or negedge rst_ni) begin : track
    pdb_result_t want;
    if (!rst_ni) begin
      interval_ms = INTERVAL_RST;
      pin_level   = 1'b0;
      change_seen = 1'b0;
      elapsed     = '0;
      rebounce_ms = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("level", 32'(want.level), 32'(level_i));
          check_field("changed", 32'(want.changed), 32'(changed_i));
          check_field("rising_edge", 32'(want.rising_edge), 32'(rising_edge_i));
          check_field("falling_edge", 32'(want.falling_edge), 32'(falling_edge_i));
          check_field("elapsed_ms", want.elapsed_ms, elapsed_ms_i);
        end
      end
      // interval write also disarms rebounce
      if (cfg_we_i) begin
        interval_ms = cfg_wdata_i;
        rebounce_ms = '0;
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(debounce_step(operation_i, level_in_i, rebounce_ms_i));
      end
      pending_o    <= expected_results.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

### test/pin_debouncer_with_rebounce_test.sv
// Stimulus and verdict for the pin debouncer, with the scoreboard beside the block
module pin_debouncer_with_rebounce_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdb_pkg::*;

  // Codes past the last defined operation
  localparam logic [2:0] OP_UNKNOWN_LO = 3'(OP_BEGIN) + 3'd1;
  localparam logic [2:0] OP_UNKNOWN_HI = '1;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [2:0]  operation   = '0;
  logic        level_in    = 1'b0;
  logic [15:0] rebounce_ms = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        level;
  logic        changed;
  logic        rising_edge;
  logic        falling_edge;
  logic [31:0] elapsed_ms;
  int          pending;
  int          mismatches;
  int          beats_sent  = 0;
  bit          stalls_on   = 1'b1;
  logic [15:0] interval_now = INTERVAL_RST;

  always #1 clk_i = ~clk_i;

  pin_debouncer_with_rebounce u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .level_in_i     (level_in),
    .rebounce_ms_i  (rebounce_ms),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .level_o        (level),
    .changed_o      (changed),
    .rising_edge_o  (rising_edge),
    .falling_edge_o (falling_edge),
    .elapsed_ms_o   (elapsed_ms)
  );

  pin_debouncer_with_rebounce_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .operation_i    (operation),
    .level_in_i     (level_in),
    .rebounce_ms_i  (rebounce_ms),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .level_i        (level),
    .changed_i      (changed),
    .rising_edge_i  (rising_edge),
    .falling_edge_i (falling_edge),
    .elapsed_ms_i   (elapsed_ms),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  // Result side: random back-pressure unless stalls are off
  always @(negedge clk_i) begin
    out_ready <= !(stalls_on && $urandom_range(0, 99) < 22);
  end

  // Offer one beat, with random gaps ahead of it, and wait until it is taken
  task automatic send_beat(input logic [2:0] op, input logic lvl, input logic [15:0] rb);
    @(negedge clk_i);
    while (stalls_on && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    level_in    <= lvl;
    rebounce_ms <= rb;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Stop sending and wait until every predicted result beat has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_interval(input logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    interval_now = value;
  endtask

  initial begin : stimulus
    logic [15:0] phase_interval [8];
    int          pick;
    int          n;
    int          phase_end;
    bit          drained_once;
    drained_once = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset interval is ten: an early change is locked out
    send_beat(OP_POLL, 1'b1, 16'h0000);

    // Zero interval: every differing poll is taken
    write_interval(16'd0);
    send_beat(OP_POLL, 1'b1, 16'h0000);
    send_beat(OP_POLL, 1'b1, 16'hFFFF);
    send_beat(OP_POLL, 1'b0, 16'h0000);
    send_beat(OP_TICK, 1'b1, 16'hFFFF);
    send_beat(OP_WRITE, 1'b1, 16'h0000);
    send_beat(OP_ARM, 1'b0, 16'hFFFF);
    send_beat(OP_ARM, 1'b1, 16'h0000);
    send_beat(OP_ARM, 1'b0, 16'h0001);
    send_beat(OP_TICK, 1'b0, 16'h0000);
    send_beat(OP_TICK, 1'b0, 16'h0000);
    // same level with rebounce expired: change flagged, level kept
    send_beat(OP_POLL, 1'b1, 16'h0000);
    // forced level keeps the old changed flag, so the edge flips
    send_beat(OP_WRITE, 1'b0, 16'hFFFF);
    send_beat(OP_BEGIN, 1'b1, 16'h0000);
    send_beat(OP_BEGIN, 1'b0, 16'hFFFF);
    send_beat(OP_UNKNOWN_LO, 1'b1, 16'hFFFF);
    send_beat(OP_UNKNOWN_LO + 3'd1, 1'b0, 16'h0000);
    send_beat(OP_UNKNOWN_HI, 1'b1, 16'hA5A5);

    // Largest interval: a differing poll is refused, rebounce still fires
    write_interval(16'hFFFF);
    send_beat(OP_TICK, 1'b0, 16'h0000);
    send_beat(OP_POLL, 1'b1, 16'h0000);
    send_beat(OP_ARM, 1'b0, 16'h0001);
    send_beat(OP_TICK, 1'b0, 16'h0000);
    send_beat(OP_POLL, 1'b0, 16'h0000);

    phase_interval = '{16'd0, 16'd3, 16'd1, 16'hFFFF, 16'($urandom), 16'd8, 16'd12, 16'd5};

    // Random part: tick bursts ending in polls, rebounce runs, level writes, noise
    for (int ph = 0; ph < 8; ph++) begin
      write_interval(phase_interval[ph]);
      stalls_on = (ph != 3);
      phase_end = beats_sent + 80;
      while (beats_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          n = (interval_now <= 20) ? $urandom_range(0, interval_now + 2)
                                   : $urandom_range(0, 20);
          repeat (n) send_beat(OP_TICK, 1'($urandom), 16'($urandom));
          send_beat(OP_POLL, 1'($urandom), 16'($urandom));
        end else if (pick < 60) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 6);
          send_beat(OP_ARM, 1'($urandom), 16'(n));
          repeat ($urandom_range(0, 8)) send_beat(OP_TICK, 1'($urandom), 16'($urandom));
          send_beat(OP_POLL, 1'($urandom), 16'($urandom));
        end else if (pick < 70) begin
          send_beat($urandom_range(0, 1) ? OP_WRITE : OP_BEGIN, 1'($urandom),
                    16'($urandom));
        end else begin
          send_beat(3'($urandom_range(0, OP_UNKNOWN_HI)), 1'($urandom), 16'($urandom));
        end
        // hold off once mid-phase until the pipeline is empty
        if (ph == 5 && !drained_once && beats_sent > phase_end - 40) begin
          wait_drained();
          drained_once = 1'b1;
        end
      end
    end
    stalls_on = 1'b1;

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
